// ===== src/sbsd_pkg.sv =====
// Package with shared types and constants of the spectroscopy block stream decoder.
`timescale 1ns / 1ps
package sbsd_pkg;
   localparam logic [2:0] KIND_RECORD      = 3'd0;
   localparam logic [2:0] KIND_BAD_MARKER  = 3'd1;
   localparam logic [2:0] KIND_BAD_SIZE    = 3'd2;
   localparam logic [2:0] KIND_NON_SPECT   = 3'd3;
   localparam logic [2:0] KIND_WRONG_SIZE  = 3'd4;
   localparam logic [2:0] KIND_BAD_BOARD   = 3'd5;
   localparam logic [2:0] KIND_TRAILING    = 3'd6;
   localparam logic [2:0] KIND_EMPTY       = 3'd7;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_HEADER = 3'd1;
   localparam logic [2:0] MODE_DATA   = 3'd2;
   localparam logic [2:0] MODE_SKIP   = 3'd3;
   localparam logic [2:0] MODE_DRAIN  = 3'd4;

   localparam logic REG_BOARD_LIMIT  = 1'b0;
   localparam logic REG_BLOCK_MARKER = 1'b1;

   localparam logic [15:0] HDR_BYTES   = 16'd9;
   localparam logic [15:0] SPECT_BLOCK = 16'd705;
   localparam logic [15:0] OFF_HG      = 16'd56;
   localparam logic [15:0] OFF_LG      = 16'd184;
   localparam logic [15:0] OFF_TOA     = 16'd312;
   localparam logic [15:0] OFF_TOT     = 16'd568;
   localparam logic [15:0] VENDOR_END  = 16'd696;

   localparam int CH_BITS = 6;

   localparam logic [1:0] LANE_HG  = 2'd0;
   localparam logic [1:0] LANE_LG  = 2'd1;
   localparam logic [1:0] LANE_TOA = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  board;
      logic [5:0]  channel;
      logic [63:0] trigger_number;
      logic [63:0] time_bits;
      logic [63:0] relative_time_bits;
      logic [15:0] over_threshold_time;
   } rec_type;

   typedef struct packed {
      logic              wr_en;
      logic [1:0]        wr_lane;
      logic [CH_BITS-1:0] wr_addr;
      logic [31:0]       wr_data;
      logic              rd_en;
      logic [CH_BITS-1:0] rd_addr;
   } buf_ctl_type;
endpackage

// ===== src/sbsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/sbsd_chbuf.sv =====
// Channel buffer: high-gain, low-gain and arrival-time memories.
`timescale 1ns / 1ps
module sbsd_chbuf (
   input  logic                 clock,
   input  sbsd_pkg::buf_ctl_type ctl,
   output logic [15:0]          high_gain,
   output logic [15:0]          low_gain,
   output logic [31:0]          arrival_time
);
   import sbsd_pkg::*;

   logic we_hg;
   logic we_lg;
   logic we_toa;

   assign we_hg  = ctl.wr_en && (ctl.wr_lane == LANE_HG);
   assign we_lg  = ctl.wr_en && (ctl.wr_lane == LANE_LG);
   assign we_toa = ctl.wr_en && (ctl.wr_lane == LANE_TOA);

   sbsd_ram #(.WIDTH(16), .DEPTH(64)) u_hg (
      .clock(clock), .wr_en(we_hg), .wr_addr(ctl.wr_addr), .wr_data(ctl.wr_data[15:0]),
      .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr), .rd_data(high_gain));
   sbsd_ram #(.WIDTH(16), .DEPTH(64)) u_lg (
      .clock(clock), .wr_en(we_lg), .wr_addr(ctl.wr_addr), .wr_data(ctl.wr_data[15:0]),
      .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr), .rd_data(low_gain));
   sbsd_ram #(.WIDTH(32), .DEPTH(64)) u_toa (
      .clock(clock), .wr_en(we_toa), .wr_addr(ctl.wr_addr), .wr_data(ctl.wr_data),
      .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr), .rd_data(arrival_time));
endmodule

// ===== src/spectroscopy_block_stream_decoder.sv =====
// Top level of the spectroscopy block stream decoder.
//
//   Channel  Direction  Contents
//   req_     in         tdata: op, payload_length, data_byte
//   rsp_     out        tdata: result record fields
//   csr_     in         board_limit (index 0), block_marker (index 1)
//
// One request is taken per cycle while req_tready is high. A record reads the
// channel buffer memories at the last byte of its over-threshold value; its
// result passes through the read stage and the output register, which holds
// while rsp_tready is low. Requests stall only while both are full and
// rsp_tready is low. Reset is synchronous; the buffer memories are not cleared.
`timescale 1ns / 1ps
module spectroscopy_block_stream_decoder #(
   parameter int LENGTH_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata bits from 0: op[0], payload_length[24:1], data_byte[32:25], zero fill
   input  logic [39:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata bits from 0: kind, board, channel, trigger_number, time_bits,
   // relative_time_bits, high_gain, low_gain, arrival_time, over_threshold_time
   output logic [295:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   import sbsd_pkg::*;

   logic                   op;
   logic [LENGTH_BITS-1:0] len;
   logic [7:0]             b;

   logic [7:0]  board_limit_ff, board_limit_in;
   logic [15:0] marker_ff, marker_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [15:0] bib_ff, bib_in;
   logic [15:0] size_ff, size_in;
   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  hboard_ff, hboard_in;
   logic [63:0] asm_ff, asm_in;
   logic [63:0] time_ff, time_in;
   logic [63:0] rtime_ff, rtime_in;
   logic [63:0] trig_ff, trig_in;
   logic [63:0] mask_ff, mask_in;

   // Stage 1: pending result waiting for memory read data.
   logic        s1_valid_ff, s1_valid_in;
   rec_type     s1_rec_ff, s1_rec_in;
   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [295:0] out_data_ff, out_data_in;

   buf_ctl_type ctl;
   logic [15:0] rd_hg, rd_lg;
   logic [31:0] rd_toa;

   logic accept;
   logic advance;
   logic emit_v;
   rec_type emit_r;

   logic [15:0] v;
   logic [3:0]  wmask;
   logic [2:0]  lane;
   logic        lane_last;
   logic [63:0] a;
   logic [15:0] k_off;
   logic [15:0] bib_next;
   logic [15:0] size_h;
   logic [31:0] qual;
   logic        spect;
   logic [2:0]  kind_h;
   logic [LENGTH_BITS:0] left_at_start;

   assign op  = req_tdata[0];
   assign len = LENGTH_BITS'(req_tdata[24:1]);
   assign b   = req_tdata[32:25];

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance || !s1_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign v = bib_ff - HDR_BYTES;
   assign size_h = asm_ff[31:16];
   assign qual = asm_ff[63:32];
   assign spect = (qual[3:0] == 4'h1) || (qual == 32'h3);
   assign left_at_start = {1'b0, left_ff} + (LENGTH_BITS+1)'(8);

   always_comb begin
      if (v < OFF_HG) begin
         wmask = 4'd7;
      end else if (v < OFF_TOA) begin
         wmask = 4'd1;
      end else if (v < OFF_TOT) begin
         wmask = 4'd3;
      end else begin
         wmask = 4'd1;
      end
      lane = v[2:0] & wmask[2:0];
      lane_last = (lane == wmask[2:0]);
   end

   always_comb begin
      board_limit_in = board_limit_ff;
      marker_in = marker_ff;
      if (csr_wr_en) begin
         if (csr_index == REG_BOARD_LIMIT) begin
            board_limit_in = csr_wdata[7:0];
         end else begin
            marker_in = csr_wdata;
         end
      end
   end

   always_comb begin
      left_in   = left_ff;
      bib_in    = bib_ff;
      size_in   = size_ff;
      mode_in   = mode_ff;
      hboard_in = hboard_ff;
      asm_in    = asm_ff;
      time_in   = time_ff;
      rtime_in  = rtime_ff;
      trig_in   = trig_ff;
      mask_in   = mask_ff;
      emit_v    = 1'b0;
      emit_r    = '0;
      ctl       = '0;
      a         = '0;
      k_off     = '0;
      kind_h    = KIND_RECORD;
      bib_next  = bib_ff + 16'd1;
      if (accept) begin
         if (!op) begin
            bib_in = '0;
            asm_in = '0;
            left_in = len;
            if (len == '0) begin
               mode_in = MODE_IDLE;
               emit_v = 1'b1;
               emit_r.kind = KIND_EMPTY;
            end else begin
               mode_in = MODE_HEADER;
            end
         end else if (mode_ff == MODE_IDLE || left_ff == '0) begin
            mode_in = MODE_IDLE;
            left_in = '0;
         end else begin
            case (mode_ff)
               MODE_HEADER: begin
                  if (bib_ff == '0 && left_ff < LENGTH_BITS'(9)) begin
                     mode_in = MODE_DRAIN;
                     emit_v = 1'b1;
                     emit_r.kind = KIND_TRAILING;
                  end else if (bib_ff < 16'd8) begin
                     if (bib_ff == '0) begin
                        asm_in = {56'd0, b};
                     end else begin
                        asm_in = asm_ff | ({56'd0, b} << {bib_ff[2:0], 3'b000});
                     end
                     bib_in = bib_next;
                  end else begin
                     hboard_in = b;
                     size_in = size_h;
                     emit_r.board = b;
                     if (asm_ff[15:0] != marker_ff) begin
                        mode_in = MODE_DRAIN;
                        emit_v = 1'b1;
                        emit_r.kind = KIND_BAD_MARKER;
                     end else if (size_h < HDR_BYTES ||
                                  {{(LENGTH_BITS+1){1'b0}}, size_h} >
                                  {16'd0, left_at_start}) begin
                        mode_in = MODE_DRAIN;
                        emit_v = 1'b1;
                        emit_r.kind = KIND_BAD_SIZE;
                     end else begin
                        bib_in = HDR_BYTES;
                        if (!spect) begin
                           kind_h = KIND_NON_SPECT;
                        end else if (size_h != SPECT_BLOCK) begin
                           kind_h = KIND_WRONG_SIZE;
                        end else if (b >= board_limit_ff) begin
                           kind_h = KIND_BAD_BOARD;
                        end
                        if (kind_h == KIND_RECORD) begin
                           mode_in = MODE_DATA;
                        end else begin
                           emit_v = 1'b1;
                           emit_r.kind = kind_h;
                           if (size_h == HDR_BYTES) begin
                              bib_in = '0;
                              mode_in = MODE_HEADER;
                           end else begin
                              mode_in = MODE_SKIP;
                           end
                        end
                     end
                  end
               end
               MODE_DATA: begin
                  if (lane == 3'd0) begin
                     a = {56'd0, b};
                  end else begin
                     a = asm_ff | ({56'd0, b} << {lane, 3'b000});
                  end
                  asm_in = a;
                  if (lane_last) begin
                     if (v < 16'd8) begin
                        time_in = a;
                     end else if (v < 16'd16) begin
                        rtime_in = a;
                     end else if (v >= 16'd32 && v < 16'd40) begin
                        trig_in = a;
                     end else if (v >= 16'd40 && v < 16'd48) begin
                        mask_in = a;
                     end else if (v >= OFF_HG && v < OFF_LG) begin
                        k_off = v - OFF_HG;
                        ctl.wr_en = 1'b1;
                        ctl.wr_lane = LANE_HG;
                        ctl.wr_addr = k_off[6:1];
                        ctl.wr_data = {16'd0, a[15:0]};
                     end else if (v >= OFF_LG && v < OFF_TOA) begin
                        k_off = v - OFF_LG;
                        ctl.wr_en = 1'b1;
                        ctl.wr_lane = LANE_LG;
                        ctl.wr_addr = k_off[6:1];
                        ctl.wr_data = {16'd0, a[15:0]};
                     end else if (v >= OFF_TOA && v < OFF_TOT) begin
                        k_off = v - OFF_TOA;
                        ctl.wr_en = 1'b1;
                        ctl.wr_lane = LANE_TOA;
                        ctl.wr_addr = k_off[7:2];
                        ctl.wr_data = a[31:0];
                     end else if (v >= OFF_TOT && v < VENDOR_END) begin
                        k_off = v - OFF_TOT;
                        if (mask_ff[k_off[6:1]]) begin
                           emit_v = 1'b1;
                           ctl.rd_en = 1'b1;
                           ctl.rd_addr = k_off[6:1];
                           emit_r.kind = KIND_RECORD;
                           emit_r.board = hboard_ff;
                           emit_r.channel = k_off[6:1];
                           emit_r.trigger_number = trig_ff;
                           emit_r.time_bits = time_ff;
                           emit_r.relative_time_bits = rtime_ff;
                           emit_r.over_threshold_time = a[15:0];
                        end
                     end
                  end
                  bib_in = bib_next;
                  if (bib_next >= size_ff) begin
                     bib_in = '0;
                     mode_in = MODE_HEADER;
                  end
               end
               MODE_SKIP: begin
                  bib_in = bib_next;
                  if (bib_next >= size_ff) begin
                     bib_in = '0;
                     mode_in = MODE_HEADER;
                  end
               end
               default: begin
               end
            endcase
            left_in = left_ff - LENGTH_BITS'(1);
            if (left_in == '0) begin
               mode_in = MODE_IDLE;
               bib_in = '0;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_rec_in    = s1_rec_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_data_in = {7'd0, s1_rec_ff.over_threshold_time, rd_toa, rd_lg, rd_hg,
                           s1_rec_ff.relative_time_bits, s1_rec_ff.time_bits,
                           s1_rec_ff.trigger_number, s1_rec_ff.channel,
                           s1_rec_ff.board, s1_rec_ff.kind};
            if (s1_rec_ff.kind != KIND_RECORD) begin
               out_data_in[272:209] = '0;
            end
         end
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = emit_v;
         s1_rec_in = emit_r;
      end
   end

   sbsd_chbuf u_chbuf (
      .clock(clock), .ctl(ctl),
      .high_gain(rd_hg), .low_gain(rd_lg), .arrival_time(rd_toa));

   always_ff @(posedge clock) begin
      if (reset) begin
         board_limit_ff <= 8'd20;
         marker_ff      <= 16'hAAAA;
         left_ff        <= '0;
         bib_ff         <= '0;
         size_ff        <= '0;
         mode_ff        <= MODE_IDLE;
         hboard_ff      <= '0;
         asm_ff         <= '0;
         time_ff        <= '0;
         rtime_ff       <= '0;
         trig_ff        <= '0;
         mask_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         board_limit_ff <= board_limit_in;
         marker_ff      <= marker_in;
         left_ff        <= left_in;
         bib_ff         <= bib_in;
         size_ff        <= size_in;
         mode_ff        <= mode_in;
         hboard_ff      <= hboard_in;
         asm_ff         <= asm_in;
         time_ff        <= time_in;
         rtime_ff       <= rtime_in;
         trig_ff        <= trig_in;
         mask_ff        <= mask_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_rec_ff   <= s1_rec_in;
      out_data_ff <= out_data_in;
   end
endmodule

// ===== test/spectroscopy_block_stream_decoder_tb.sv =====
// Self-checking testbench: directed and random payloads against a predictor of the decoder.
`timescale 1ns / 1ps
module spectroscopy_block_stream_decoder_tb;
   import sbsd_pkg::*;

   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // Packed from the highest tdata bit down, so kind sits in the lowest bits.
   typedef struct packed {
      logic [15:0] over_threshold_time;
      logic [31:0] arrival_time;
      logic [15:0] low_gain;
      logic [15:0] high_gain;
      logic [63:0] relative_time_bits;
      logic [63:0] time_bits;
      logic [63:0] trigger_number;
      logic [5:0]  channel;
      logic [7:0]  board;
      logic [2:0]  kind;
   } result_type;

   typedef struct {
      logic        op;
      logic [23:0] len;
      logic [7:0]  data;
      logic        has_typed;
      logic [2:0]  typed_kind;
      logic [7:0]  typed_board;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [295:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   spectroscopy_block_stream_decoder dut (.*);

   always #2 clock = ~clock;

   // Predictor state.
   logic [7:0]  board_limit_q;
   logic [15:0] block_marker_q;
   logic [23:0] payload_left;
   logic [15:0] byte_in_block;
   logic [15:0] blk_size;
   logic [2:0]  parse_mode;
   logic [31:0] qualifier;
   logic [7:0]  blk_board;
   logic [63:0] assembly;
   logic [63:0] blk_time, blk_rel_time, blk_trigger, chan_mask;
   logic [63:0] chan_buf [64];

   result_type expected_results[$];
   int errors = 0;
   int idle_pct = 24;
   stim_type directed[$];
   logic [7:0] pay[$];

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic void push_result(logic [2:0] kind, logic [7:0] board);
      result_type r;
      r = '0;
      r.kind = kind;
      r.board = board;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_header(logic [7:0] b);
      logic [15:0] marker, size;
      logic [31:0] left_at_start;
      logic spect;
      logic [2:0] kind;
      if (byte_in_block < 8) begin
         if (byte_in_block == 0) assembly = 64'(b);
         else assembly |= 64'(b) << (8 * byte_in_block);
         byte_in_block++;
         return;
      end
      marker = assembly[15:0];
      size = assembly[31:16];
      left_at_start = 32'(payload_left) + 8;
      qualifier = assembly[63:32];
      blk_board = b;
      blk_size = size;
      if (marker != block_marker_q) begin
         parse_mode = MODE_DRAIN;
         push_result(KIND_BAD_MARKER, b);
         return;
      end
      if (size < HDR_BYTES || 32'(size) > left_at_start) begin
         parse_mode = MODE_DRAIN;
         push_result(KIND_BAD_SIZE, b);
         return;
      end
      byte_in_block = HDR_BYTES;
      spect = (qualifier[3:0] == 4'h1) || (qualifier == 32'h3);
      kind = KIND_RECORD;
      if (!spect) kind = KIND_NON_SPECT;
      else if (size != SPECT_BLOCK) kind = KIND_WRONG_SIZE;
      else if (b >= board_limit_q) kind = KIND_BAD_BOARD;
      if (kind == KIND_RECORD) begin
         parse_mode = MODE_DATA;
         return;
      end
      if (size == HDR_BYTES) begin
         byte_in_block = 0;
         parse_mode = MODE_HEADER;
      end else begin
         parse_mode = MODE_SKIP;
      end
      push_result(kind, b);
   endfunction

   function automatic void predict_data(logic [7:0] b);
      int v, w, lane, c;
      result_type r;
      v = int'(byte_in_block) - 9;
      if (v < 56) w = 8;
      else if (v < 312) w = 2;
      else if (v < 568) w = 4;
      else w = 2;
      lane = v & (w - 1);
      if (lane == 0) assembly = 64'(b);
      else assembly |= 64'(b) << (8 * lane);
      if (lane != w - 1) return;
      if (v < 8) blk_time = assembly;
      else if (v < 16) blk_rel_time = assembly;
      else if (v >= 32 && v < 40) blk_trigger = assembly;
      else if (v >= 40 && v < 48) chan_mask = assembly;
      else if (v >= 56 && v < 184) begin
         c = ((v - 56) >> 1) & 63;
         chan_buf[c][15:0] = assembly[15:0];
      end else if (v >= 184 && v < 312) begin
         c = ((v - 184) >> 1) & 63;
         chan_buf[c][31:16] = assembly[15:0];
      end else if (v >= 312 && v < 568) begin
         c = ((v - 312) >> 2) & 63;
         chan_buf[c][63:32] = assembly[31:0];
      end else if (v >= 568 && v < 696) begin
         c = ((v - 568) >> 1) & 63;
         if (chan_mask[c]) begin
            r.kind = KIND_RECORD;
            r.board = blk_board;
            r.channel = 6'(c);
            r.trigger_number = blk_trigger;
            r.time_bits = blk_time;
            r.relative_time_bits = blk_rel_time;
            r.high_gain = chan_buf[c][15:0];
            r.low_gain = chan_buf[c][31:16];
            r.arrival_time = chan_buf[c][63:32];
            r.over_threshold_time = assembly[15:0];
            expected_results.push_back(r);
         end
      end
   endfunction

   function automatic void predict_request(logic op, logic [23:0] len, logic [7:0] b);
      if (op == OP_START) begin
         byte_in_block = 0;
         assembly = 0;
         payload_left = len;
         if (len == 0) begin
            parse_mode = MODE_IDLE;
            push_result(KIND_EMPTY, 8'd0);
         end else begin
            parse_mode = MODE_HEADER;
         end
         return;
      end
      if (parse_mode == MODE_IDLE || payload_left == 0) begin
         parse_mode = MODE_IDLE;
         payload_left = 0;
         return;
      end
      case (parse_mode)
         MODE_HEADER: begin
            if (byte_in_block == 0 && payload_left < 9) begin
               parse_mode = MODE_DRAIN;
               push_result(KIND_TRAILING, 8'd0);
            end else begin
               predict_header(b);
            end
         end
         MODE_DATA, MODE_SKIP: begin
            if (parse_mode == MODE_DATA) predict_data(b);
            byte_in_block++;
            if (byte_in_block >= blk_size) begin
               byte_in_block = 0;
               parse_mode = MODE_HEADER;
            end
         end
         default: ;
      endcase
      payload_left--;
      if (payload_left == 0) begin
         parse_mode = MODE_IDLE;
         byte_in_block = 0;
      end
   endfunction

   task automatic send_request(logic op, logic [23:0] len, logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, b, len, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(op, len, b);
   endtask

   // Starts a payload of the given length and sends the queued bytes.
   task automatic send_partial(logic [23:0] len);
      send_request(OP_START, len, 8'd0);
      foreach (pay[i]) send_request(OP_BYTE, 24'($urandom), pay[i]);
   endtask

   task automatic send_payload();
      send_partial(24'(pay.size()));
   endtask

   task automatic add_header(logic [15:0] marker, logic [15:0] size, logic [31:0] qual,
                             logic [7:0] board);
      for (int i = 0; i < 2; i++) pay.push_back(marker[8*i +: 8]);
      for (int i = 0; i < 2; i++) pay.push_back(size[8*i +: 8]);
      for (int i = 0; i < 4; i++) pay.push_back(qual[8*i +: 8]);
      pay.push_back(board);
   endtask

   // A spectroscopy block with random contents; mask_mode 0 random, 1 all, 2 sparse.
   task automatic add_spect_block(logic [7:0] board, int mask_mode);
      logic [63:0] mask;
      logic [31:0] qual;
      qual = $urandom_range(1) ? 32'h3 : {28'($urandom), 4'h1};
      add_header(block_marker_q, SPECT_BLOCK, qual, board);
      mask = {$urandom, $urandom};
      if (mask_mode == 1) mask = '1;
      if (mask_mode == 2) mask = mask & {$urandom, $urandom} & {$urandom, $urandom};
      for (int v = 0; v < 696; v++) begin
         if (v >= 40 && v < 48) pay.push_back(mask[8*(v-40) +: 8]);
         else pay.push_back(8'($urandom));
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_BOARD_LIMIT) board_limit_q = value[7:0];
      else block_marker_q = value;
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[288:0]);
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d", got.kind));
         end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind)
               report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.board != want.board)
               report_mismatch($sformatf("board %0d want %0d", got.board, want.board));
            if (got.channel != want.channel)
               report_mismatch($sformatf("channel %0d want %0d", got.channel, want.channel));
            if (got.trigger_number != want.trigger_number)
               report_mismatch("trigger_number");
            if (got.time_bits != want.time_bits) report_mismatch("time_bits");
            if (got.relative_time_bits != want.relative_time_bits)
               report_mismatch("relative_time_bits");
            if (got.high_gain != want.high_gain) report_mismatch("high_gain");
            if (got.low_gain != want.low_gain) report_mismatch("low_gain");
            if (got.arrival_time != want.arrival_time) report_mismatch("arrival_time");
            if (got.over_threshold_time != want.over_threshold_time)
               report_mismatch("over_threshold_time");
         end
      end
   end

   initial begin
      #20_000_000;
      $display("spectroscopy_block_stream_decoder_tb: FAIL");
      $finish;
   end

   initial begin
      stim_type s;
      int n, kind_sel;
      board_limit_q = 8'd20;
      block_marker_q = 16'hAAAA;
      payload_left = 0;
      byte_in_block = 0;
      blk_size = 0;
      parse_mode = MODE_IDLE;
      qualifier = 0;
      blk_board = 0;
      assembly = 0;
      blk_time = 0;
      blk_rel_time = 0;
      blk_trigger = 0;
      chan_mask = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty payload, bytes while idle, full length, extremes.
      s = '{OP_START, 24'd0, 8'd0, 1'b1, KIND_EMPTY, 8'd0};
      directed.push_back(s);
      s = '{OP_BYTE, 24'hFFFFFF, 8'hFF, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_BYTE, 24'd0, 8'h00, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_START, 24'hFFFFFF, 8'hFF, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_START, 24'd3, 8'd0, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_BYTE, 24'd0, 8'h55, 1'b1, KIND_TRAILING, 8'd0};
      directed.push_back(s);
      s = '{OP_BYTE, 24'd0, 8'hAA, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_BYTE, 24'd0, 8'h12, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_BYTE, 24'd0, 8'h34, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      s = '{OP_START, 24'd9, 8'd0, 1'b0, KIND_RECORD, 8'd0};
      directed.push_back(s);
      for (int i = 0; i < 8; i++) begin
         s = '{OP_BYTE, 24'd0, 8'h00, 1'b0, KIND_RECORD, 8'd0};
         directed.push_back(s);
      end
      s = '{OP_BYTE, 24'd0, 8'hFF, 1'b1, KIND_BAD_MARKER, 8'hFF};
      directed.push_back(s);
      foreach (directed[i]) begin
         if (directed[i].has_typed) begin
            wait_drained();
            expected_results.push_back('0);
         end
         n = expected_results.size();
         send_request(directed[i].op, directed[i].len, directed[i].data);
         if (directed[i].has_typed) begin
            // The typed expectation replaces the predicted one.
            if (expected_results.size() != n + 1
                || expected_results[n].kind != directed[i].typed_kind
                || expected_results[n].board != directed[i].typed_board)
               report_mismatch($sformatf("directed row %0d prediction", i));
            if (expected_results.size() == n + 1) begin
               expected_results.delete(n);
               expected_results[n-1].kind = directed[i].typed_kind;
               expected_results[n-1].board = directed[i].typed_board;
            end
         end
      end

      // Header kinds with default registers.
      pay.delete();
      add_header(16'hAAAA, 16'd9, 32'h2, 8'd1);
      add_header(16'hAAAA, 16'd12, 32'h1, 8'd2);
      repeat (3) pay.push_back(8'h00);
      add_header(16'hAAAA, 16'd9, 32'h11, 8'd20);
      add_header(16'hAAAA, 16'd9, 32'h3, 8'hFF);
      add_header(16'hAAAA, 16'd9, 32'h13, 8'd0);
      add_header(16'hAAAA, 16'd8, 32'h1, 8'd3);
      send_payload();
      pay.delete();
      add_header(16'hAAAA, 16'hFFFF, 32'h1, 8'd3);
      send_payload();
      pay.delete();
      add_header(16'hAAAA, SPECT_BLOCK, 32'h1, 8'd20);
      send_partial(24'd800);
      pay.delete();
      add_spect_block(8'd19, 1);
      send_payload();

      write_reg(REG_BOARD_LIMIT, 16'd255);
      write_reg(REG_BLOCK_MARKER, 16'h0000);
      pay.delete();
      add_header(16'h0000, SPECT_BLOCK, 32'h3, 8'd255);
      send_partial(24'd705);
      pay.delete();
      add_header(16'h0000, SPECT_BLOCK, 32'h3, 8'd254);
      repeat (20) pay.push_back(8'($urandom));
      send_partial(24'd705);

      idle_pct = 0;
      write_reg(REG_BOARD_LIMIT, 16'd1);
      write_reg(REG_BLOCK_MARKER, 16'hFFFF);
      pay.delete();
      for (int i = 0; i < 12; i++)
         add_header(16'hFFFF, 16'd9, (i % 2 == 0) ? 32'h1 : 32'h2, 8'(i));
      send_payload();
      pay.delete();
      add_header(16'hFFFF, SPECT_BLOCK, 32'h1, 8'd1);
      send_partial(24'd1000);
      idle_pct = 24;

      // Random payloads of short blocks.
      for (int phase = 0; phase < 3; phase++) begin
         write_reg(REG_BOARD_LIMIT, 16'($urandom_range(255, 1)));
         write_reg(REG_BLOCK_MARKER, 16'($urandom));
         for (int p = 0; p < 3; p++) begin
            pay.delete();
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++) begin
               kind_sel = $urandom_range(9, 4);
               if (kind_sel == 4)
                  add_header(block_marker_q, 16'($urandom_range(30, 9)),
                             {28'($urandom), 4'h2}, 8'($urandom));
               else if (kind_sel == 5)
                  add_header(block_marker_q, 16'd9, 32'h1, 8'($urandom));
               else if (kind_sel == 6)
                  add_header(16'($urandom), 16'($urandom), $urandom, 8'($urandom));
               else if (kind_sel == 7)
                  add_header(block_marker_q, 16'($urandom_range(8)), 32'h1, 8'($urandom));
               else
                  repeat ($urandom_range(12)) pay.push_back(8'($urandom));
               if (kind_sel == 4)
                  repeat (int'(pay[pay.size()-7]) - 9) pay.push_back(8'($urandom));
            end
            if ($urandom_range(3) == 0) repeat ($urandom_range(8)) pay.push_back(8'($urandom));
            if ($urandom_range(7) == 0) begin
               send_request(OP_START, 24'($urandom_range(40, 1)), 8'($urandom));
               repeat ($urandom_range(5)) send_request(OP_BYTE, 24'($urandom), 8'($urandom));
            end
            send_payload();
         end
      end

      wait_drained();
      if (errors == 0 && expected_results.size() == 0)
         $display("spectroscopy_block_stream_decoder_tb: PASS");
      else
         $display("spectroscopy_block_stream_decoder_tb: FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
src/sbsd_pkg.sv
src/sbsd_ram.sv
src/sbsd_chbuf.sv
src/spectroscopy_block_stream_decoder.sv
test/spectroscopy_block_stream_decoder_tb.sv
